// File: design/ara_pkg.sv
// Shared types and constants for the address range allocator.
package ara_pkg;

    localparam int MAX_RANGES = 16;
    localparam int ADDR_BITS  = 32;
    localparam int PAGE_BYTES = 4096;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int PAGE_SH    = $clog2(PAGE_BYTES);

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FAULT = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_NOFAULT  = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] start_addr;
        logic [31:0] length;
        logic        fixed;
        logic        map_kind;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] range_start;
        logic [31:0] range_end;
        logic [19:0] page_index;
        logic [3:0]  slot;
    } rsp_t;

    // datapath commands
    typedef enum logic [3:0] {
        CMD_NONE  = 4'd0,
        CMD_LOAD  = 4'd1,  // latch request, round size, reset scan index
        CMD_EXACT = 4'd2,  // one exact-placement compare, index++
        CMD_FIRST = 4'd3,  // set first-fit base
        CMD_FSTEP = 4'd4,  // one first-fit step
        CMD_FAULT = 4'd5,  // one fault compare
        CMD_SHIFT = 4'd6,  // move entry idx-1 to idx, idx--
        CMD_PUT   = 4'd7,  // write new entry at pos, count++
        CMD_CLEAR = 4'd8
    } cmd_e;

    typedef struct packed {
        cmd_e cmd;
        logic idx_to_count; // for shift: start index at count
    } ctl_t;

    typedef struct packed {
        logic       full;
        logic       zero_size;
        logic       ovf;        // current placement overflow
        logic       hit_exact;  // entry at idx overlaps the requested range
        logic       hit_first;  // entry at idx starts at or past first-fit end
        logic       hit_fault;  // entry at idx holds the faulting page
        logic       idx_end;    // scan index reached count
        logic       idx_at_pos;
        logic       fit_fail;   // first-fit end >= limit
    } sts_t;

endpackage

// File: design/address_range_allocator.sv
// Address range allocator: command FSM, range table and result register.
// Steps: allocate does an exact scan, a first-fit scan, then one entry shift per
// cycle; fault scans the table for the faulting page; clear empties the table.
// One command at a time: busy stays high through the strobe cycle, so the
// next word is taken in the cycle after the strobe. Strobe lasts one cycle; no stall.
// Reset (rst_n async low): table empty, user_limit 0xC0000000, idle.
module address_range_allocator
    import ara_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        req,
    output logic        done,
    output rsp_t        rsp,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    logic [31:0] limit_reg;
    ctl_t        ctl;
    sts_t        sts;
    logic        dp_done;
    logic [1:0]  res_status;
    logic        res_fault;
    logic [31:0] base_w, hs, he;
    logic [32:0] end_w;
    logic [IDX_W-1:0] pos_w, idx_w;
    logic [31:0] page;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= 32'hC000_0000;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    ara_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .func(req.func),
        .fixed(req.fixed), .nonzero_addr(req.start_addr != '0),
        .sts(sts), .ctl(ctl), .busy(busy), .done(dp_done),
        .res_status(res_status), .res_fault(res_fault)
    );

    ara_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .req(req),
        .user_limit(limit_reg), .ctl(ctl), .sts(sts),
        .base_out(base_w), .end_out(end_w), .pos_out(pos_w),
        .hit_start(hs), .hit_end(he), .idx_out(idx_w)
    );

    // result word assembled in the done cycle; page base from the latched addr
    // is re-derived through the hit entry start
    logic [31:0] fault_addr_reg;
    logic [1:0]  cmd_func_reg;
    always_ff @(posedge clk)
    begin
        if (!busy && start)
        begin
            fault_addr_reg <= req.start_addr;
            cmd_func_reg   <= req.func;
        end
    end
    assign page = {fault_addr_reg[31:PAGE_SH], {PAGE_SH{1'b0}}};

    logic [31:0] pdiff;
    assign pdiff = page - hs;

    // placed range is shown only for a successful allocate
    always_comb
    begin
        rsp = '0;
        rsp.status = res_status;
        if (res_fault)
        begin
            rsp.range_start = hs;
            rsp.range_end   = he;
            rsp.page_index  = 20'(pdiff >> PAGE_SH);
            rsp.slot        = 4'(idx_w);
        end
        else if (res_status == ST_OK && cmd_func_reg == FUNC_ALLOC && dp_done
                 && base_w != '0)
        begin
            rsp.range_start = base_w;
            rsp.range_end   = end_w[31:0];
            rsp.slot        = 4'(pos_w);
        end
    end

    assign done = dp_done;

endmodule

// File: design/ara_datapath.sv
// Range table storage and the compare/shift datapath.
module ara_datapath
    import ara_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  req_t        req,
    input  logic [31:0] user_limit,
    input  ctl_t        ctl,
    output sts_t        sts,
    output logic [31:0] base_out,
    output logic [32:0] end_out,
    output logic [IDX_W-1:0] pos_out,
    output logic [31:0] hit_start,
    output logic [31:0] hit_end,
    output logic [IDX_W-1:0] idx_out
);

    logic [31:0] starts_mem [MAX_RANGES];
    logic [31:0] ends_mem   [MAX_RANGES];
    logic        kinds_mem  [MAX_RANGES];

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [32:0] size_reg, size_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] addr_reg;
    logic        kind_reg;

    logic [IDX_W-1:0] ix;
    logic [31:0] e_s, e_e;
    logic        e_k;
    logic [32:0] end_c;
    logic [32:0] rounded;
    logic [31:0] page;

    assign ix  = idx_reg[IDX_W-1:0];
    assign e_s = starts_mem[ix];
    assign e_e = ends_mem[ix];
    assign e_k = kinds_mem[ix];
    assign end_c = {1'b0, base_reg} + size_reg;
    assign page  = {addr_reg[31:PAGE_SH], {PAGE_SH{1'b0}}};

    always_comb
    begin
        rounded = {1'b0, req.length};
        if (req.map_kind && (req.length[PAGE_SH-1:0] != '0))
            rounded = {1'b0, req.length[31:PAGE_SH], {PAGE_SH{1'b0}}}
                      + 33'(PAGE_BYTES);
    end

    always_comb
    begin
        sts.full       = (count_reg >= CNT_W'(MAX_RANGES));
        sts.zero_size  = (size_reg == '0);
        sts.ovf        = end_c[32];
        sts.idx_end    = (idx_reg >= count_reg);
        sts.idx_at_pos = (idx_reg == {1'b0, pos_reg});
        sts.fit_fail   = (end_c >= {1'b0, user_limit});
        sts.hit_exact  = (e_s < end_c[31:0]) && (base_reg < e_e);
        sts.hit_first  = ({1'b0, e_s} >= end_c);
        sts.hit_fault  = !e_k && (page >= e_s) && (e_e >= 32'(PAGE_BYTES))
                         && (page <= e_e - 32'(PAGE_BYTES));
    end

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        size_next  = size_reg;
        base_next  = base_reg;
        unique case (ctl.cmd)
            CMD_LOAD:
            begin
                size_next = rounded;
                base_next = req.start_addr;
                idx_next  = '0;
                pos_next  = '0;
            end
            CMD_EXACT:
            begin
                if (e_e <= base_reg)
                    pos_next = IDX_W'(idx_reg + 1'b1);
                idx_next = idx_reg + 1'b1;
            end
            CMD_FIRST:
            begin
                base_next = 32'(PAGE_BYTES);
                idx_next  = '0;
                pos_next  = count_reg[IDX_W-1:0];
            end
            CMD_FSTEP:
            begin
                if (sts.hit_first)
                    pos_next = ix;
                else if (e_e > base_reg)
                    base_next = e_e;
                idx_next = idx_reg + 1'b1;
            end
            CMD_FAULT: idx_next = idx_reg + 1'b1;
            CMD_SHIFT:
            begin
                if (ctl.idx_to_count)
                    idx_next = count_reg;
                else
                    idx_next = idx_reg - 1'b1;
            end
            CMD_PUT:   count_next = count_reg + 1'b1;
            CMD_CLEAR: count_next = '0;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        size_reg <= size_next;
        base_reg <= base_next;
        if (ctl.cmd == CMD_LOAD)
        begin
            addr_reg <= req.start_addr;
            kind_reg <= req.map_kind;
        end
        if (ctl.cmd == CMD_SHIFT && !ctl.idx_to_count)
        begin
            starts_mem[ix] <= starts_mem[IDX_W'(idx_reg - 1'b1)];
            ends_mem[ix]   <= ends_mem[IDX_W'(idx_reg - 1'b1)];
            kinds_mem[ix]  <= kinds_mem[IDX_W'(idx_reg - 1'b1)];
        end
        if (ctl.cmd == CMD_PUT)
        begin
            starts_mem[pos_reg] <= base_reg;
            ends_mem[pos_reg]   <= end_c[31:0];
            kinds_mem[pos_reg]  <= kind_reg;
        end
    end

    assign base_out  = base_reg;
    assign end_out   = end_c;
    assign pos_out   = pos_reg;
    assign hit_start = e_s;
    assign hit_end   = e_e;
    assign idx_out   = ix;

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RANGES))
        else $error("range count above table size");
    a_put_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.cmd == CMD_PUT |-> count_reg < CNT_W'(MAX_RANGES))
        else $error("insert into full table");
    a_put_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.cmd == CMD_PUT |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow table");
`endif

endmodule

// File: design/ara_ctrl.sv
// Sequencing state machine for allocate, fault and clear.
module ara_ctrl
    import ara_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  func,
    input  logic        fixed,
    input  logic        nonzero_addr,
    input  sts_t        sts,
    output ctl_t        ctl,
    output logic        busy,
    output logic        done,
    output logic [1:0]  res_status,
    output logic        res_fault   // fault hit when done with ST_OK
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_EXACT = 9'b000000100,
        S_FIRST = 9'b000001000,
        S_FSTEP = 9'b000010000,
        S_FEND  = 9'b000100000,
        S_SHIFT = 9'b001000000,
        S_FAULT = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] func_reg;
    logic       fixed_reg, nz_reg;
    logic [1:0] st_reg, st_next;
    logic       flt_reg, flt_next;

    always_comb
    begin
        state_next  = state_reg;
        st_next     = st_reg;
        flt_next    = flt_reg;
        ctl.cmd     = CMD_NONE;
        ctl.idx_to_count = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.cmd    = CMD_LOAD;
                    st_next    = ST_OK;
                    flt_next   = 1'b0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (func_reg == FUNC_CLEAR)
                begin
                    ctl.cmd = CMD_CLEAR;
                    state_next = S_DONE;
                end
                else if (func_reg == FUNC_FAULT)
                    state_next = S_FAULT;
                else if (func_reg != FUNC_ALLOC)
                begin
                    st_next = ST_NOFAULT;
                    state_next = S_DONE;
                end
                else if (sts.full)
                begin
                    st_next = ST_OVERFLOW;
                    state_next = S_DONE;
                end
                else if (sts.zero_size)
                begin
                    st_next = ST_NOSPACE;
                    state_next = S_DONE;
                end
                else if (!nz_reg)
                    state_next = S_FIRST;
                else if (sts.ovf)
                begin
                    if (fixed_reg)
                    begin
                        st_next = ST_OVERFLOW;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_FIRST;
                end
                else
                    state_next = S_EXACT;
            end
            S_EXACT:
            begin
                priority if (sts.idx_end)
                begin
                    ctl.cmd = CMD_SHIFT;
                    ctl.idx_to_count = 1'b1;
                    state_next = S_SHIFT;
                end
                else if (sts.hit_exact)
                begin
                    if (fixed_reg)
                    begin
                        st_next = ST_NOSPACE;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_FIRST;
                end
                else
                    ctl.cmd = CMD_EXACT;
            end
            S_FIRST:
            begin
                ctl.cmd = CMD_FIRST;
                state_next = S_FSTEP;
            end
            S_FSTEP:
            begin
                priority if (sts.ovf)
                begin
                    st_next = ST_OVERFLOW;
                    state_next = S_DONE;
                end
                else if (sts.idx_end)
                    state_next = S_FEND;
                else
                begin
                    ctl.cmd = CMD_FSTEP;
                    if (sts.hit_first)
                        state_next = S_FEND;
                end
            end
            S_FEND:
            begin
                if (sts.fit_fail)
                begin
                    st_next = ST_NOSPACE;
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.cmd = CMD_SHIFT;
                    ctl.idx_to_count = 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (sts.idx_at_pos)
                begin
                    ctl.cmd = CMD_PUT;
                    state_next = S_DONE;
                end
                else
                    ctl.cmd = CMD_SHIFT;
            end
            S_FAULT:
            begin
                priority if (sts.idx_end)
                begin
                    st_next = ST_NOFAULT;
                    state_next = S_DONE;
                end
                else if (sts.hit_fault)
                begin
                    flt_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                    ctl.cmd = CMD_FAULT;
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            st_reg     <= ST_OK;
            flt_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            st_reg     <= st_next;
            flt_reg    <= flt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            func_reg  <= func;
            fixed_reg <= fixed;
            nz_reg    <= nonzero_addr;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_DONE);
    assign res_status = st_reg;
    assign res_fault  = flt_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> state_reg == S_CHECK)
        else $error("accepted command did not start");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held two cycles");
    a_fault_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && flt_reg) |-> st_reg == ST_OK)
        else $error("fault hit with bad status");
`endif

endmodule

// File: tb/tb_address_range_allocator.sv
`timescale 1ns / 1ps
// Testbench for the address range allocator: directed and random commands checked against a model.
module tb_address_range_allocator;
    import ara_pkg::*;

    // Expected-result store with its own copy of the range table.
    class range_table_sb;
        logic [31:0] lim;
        logic [31:0] starts[MAX_RANGES];
        logic [31:0] ends[MAX_RANGES];
        logic        kinds[MAX_RANGES];
        int          count;
        rsp_t        pending[$];
        int          errors;

        function void clear_all();
            lim = 32'hC000_0000;
            count = 0;
            pending.delete();
            errors = 0;
        endfunction

        // exact placement: returns status code, pos by ref
        function logic [1:0] try_exact(logic [63:0] base, logic [63:0] size, ref int pos);
            logic [63:0] e;
            int p;
            p = 0;
            if (base + size > 64'hFFFF_FFFF) return ST_OVERFLOW;
            e = base + size;
            for (int i = 0; i < count; i++) begin
                if (starts[i] < e && base < ends[i]) return ST_NOSPACE;
                if (ends[i] <= base) p = i + 1;
            end
            pos = p;
            return ST_OK;
        endfunction

        function logic [1:0] try_first(logic [63:0] size, ref logic [63:0] base, ref int pos);
            logic [63:0] b;
            logic [63:0] e;
            int p;
            b = 64'(PAGE_BYTES);
            if (b + size > 64'hFFFF_FFFF) return ST_OVERFLOW;
            e = b + size;
            p = count;
            for (int i = 0; i < count; i++) begin
                if (starts[i] >= e) begin
                    p = i;
                    break;
                end
                if (ends[i] > b) begin
                    b = ends[i];
                    if (b + size > 64'hFFFF_FFFF) return ST_OVERFLOW;
                    e = b + size;
                end
            end
            if (e >= {32'd0, lim}) return ST_NOSPACE;
            base = b;
            pos = p;
            return ST_OK;
        endfunction

        // note an accepted word and queue its expected response
        function void note_request(req_t r);
            rsp_t o;
            logic [63:0] size;
            logic [63:0] base;
            logic [63:0] pg;
            logic [1:0] st;
            int pos;
            o = '0;
            pos = 0;
            base = 0;
            size = {32'd0, r.length};
            if (r.func == FUNC_ALLOC) begin
                if (r.map_kind && size[11:0] != 0) size = {size[63:12] + 1, 12'd0};
                if (count >= MAX_RANGES) o.status = ST_OVERFLOW;
                else if (size == 0) o.status = ST_NOSPACE;
                else begin
                    st = ST_NOSPACE;
                    if (r.start_addr != 0) begin
                        st = try_exact({32'd0, r.start_addr}, size, pos);
                        if (st == ST_OK) base = r.start_addr;
                    end
                    if (st != ST_OK && !(r.start_addr != 0 && r.fixed))
                        st = try_first(size, base, pos);
                    if (st != ST_OK) o.status = st;
                    else begin
                        for (int i = count; i > pos; i--) begin
                            starts[i] = starts[i-1];
                            ends[i] = ends[i-1];
                            kinds[i] = kinds[i-1];
                        end
                        starts[pos] = base[31:0];
                        ends[pos] = base[31:0] + size[31:0];
                        kinds[pos] = r.map_kind;
                        count++;
                        o.range_start = base[31:0];
                        o.range_end = base[31:0] + size[31:0];
                        o.slot = pos[3:0];
                    end
                end
            end else if (r.func == FUNC_FAULT) begin
                pg = {32'd0, r.start_addr[31:12], 12'd0};
                o.status = ST_NOFAULT;
                for (int i = 0; i < count; i++) begin
                    if (!kinds[i] && pg >= starts[i] && ends[i] >= PAGE_BYTES
                        && pg <= ends[i] - PAGE_BYTES) begin
                        o.status = ST_OK;
                        o.range_start = starts[i];
                        o.range_end = ends[i];
                        // range start need not be page aligned
                        o.page_index = 20'((pg[31:0] - starts[i]) >> PAGE_SH);
                        o.slot = i[3:0];
                        break;
                    end
                end
            end else if (r.func == FUNC_CLEAR) count = 0;
            else o.status = ST_NOFAULT;
            pending.push_back(o);
        endfunction

        function void check_response(rsp_t got);
            rsp_t w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.status !== w.status || got.range_start !== w.range_start ||
                got.range_end !== w.range_end || got.page_index !== w.page_index ||
                got.slot !== w.slot) begin
                $display("%0t: mismatch expected %h actual %h", $time, w, got);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req;
    logic        done;
    rsp_t        rsp;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    int          cycles;
    bit          quiet;     // no idle gaps while set
    range_table_sb sb;

    address_range_allocator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Responses are sampled at the edge; receiver never stalls.
    always @(posedge clk)
        if (rst_n && done) sb.check_response(rsp);

    // Generous watchdog: reports TB_ERROR and stops the run if it hangs.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Issue one word; start stays high until accepted (start high and busy low)
    // and is left high so back-to-back words need no extra drive.
    task automatic send_word(req_t r);
        while (!quiet && $urandom_range(99) < 29) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (3 * MAX_RANGES + 10) @(posedge clk);
    endtask

    // Register write only while idle.
    task automatic set_limit(logic [31:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.lim = v;
    endtask

    function automatic req_t mk(logic [1:0] f, logic [31:0] a, logic [31:0] l,
                                logic fx, logic k);
        req_t r;
        r.func = f;
        r.start_addr = a;
        r.length = l;
        r.fixed = fx;
        r.map_kind = k;
        return r;
    endfunction

    // Random word biased toward page-scaled, overlapping placements.
    function automatic req_t rand_word();
        req_t r;
        int sel;
        sel = $urandom_range(99);
        r.fixed = 1'($urandom_range(1));
        r.map_kind = 1'($urandom_range(1));
        r.start_addr = 0;
        if ($urandom_range(3) != 0)
            r.start_addr = 32'($urandom_range(64) * PAGE_BYTES + ($urandom_range(3) == 0 ?
                           $urandom_range(4095) : 0));
        r.length = 32'(($urandom_range(8) + ($urandom_range(3) == 0 ? 0 : 1)) * PAGE_BYTES
                   + ($urandom_range(2) == 0 ? $urandom_range(4095) : 0));
        if (sel < 55) r.func = FUNC_ALLOC;
        else if (sel < 88) r.func = FUNC_FAULT;
        else if (sel < 95) r.func = FUNC_CLEAR;
        else if (sel < 97) r.func = 2'd3;
        else begin
            // noise: full-width values
            r.func = 2'($urandom_range(1));
            r.start_addr = $urandom;
            r.length = $urandom;
        end
        return r;
    endfunction

    initial begin
        sb = new();
        sb.clear_all();
        rst_n = 0;
        start = 0;
        req = '0;
        cfg_we = 0;
        cfg_wdata = '0;
        cycles = 0;
        quiet = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero length, overflow, fixed overlap, file faults
        send_word(mk(FUNC_ALLOC, 32'h0, 32'h0, 0, 0));
        send_word(mk(FUNC_ALLOC, 32'h0, 32'h0, 0, 1));
        send_word(mk(FUNC_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0));
        send_word(mk(FUNC_ALLOC, 32'hFFFF_F000, 32'h2000, 0, 0));
        send_word(mk(FUNC_ALLOC, 32'h0, 32'hFFFF_FFFF, 0, 1));
        send_word(mk(FUNC_ALLOC, 32'h0000_2000, 32'h1001, 0, 0));
        send_word(mk(FUNC_ALLOC, 32'h0000_2800, 32'h10, 1, 0));
        send_word(mk(FUNC_ALLOC, 32'h0000_2800, 32'h10, 0, 1));
        send_word(mk(FUNC_ALLOC, 32'hF000_0000, 32'h1FFF, 0, 0));
        send_word(mk(FUNC_FAULT, 32'h0000_2FFF, 32'h0, 0, 0));
        send_word(mk(FUNC_FAULT, 32'h0000_1234, 32'h0, 0, 0));
        send_word(mk(FUNC_FAULT, 32'hF000_1FFF, 32'h0, 0, 0));
        send_word(mk(FUNC_FAULT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1));
        send_word(mk(2'd3, 32'h1234_5678, 32'h9, 1, 1));
        send_word(mk(FUNC_CLEAR, 32'h0, 32'h0, 0, 0));
        // fill the table, then one more
        for (int i = 0; i <= MAX_RANGES; i++)
            send_word(mk(FUNC_ALLOC, 32'h0, 32'h1000, 0, i[0]));
        send_word(mk(FUNC_CLEAR, 32'h0, 32'h0, 0, 0));
        // tight limit: first fit fails
        set_limit(32'h0000_1000);
        send_word(mk(FUNC_ALLOC, 32'h0, 32'h1, 0, 0));
        send_word(mk(FUNC_ALLOC, 32'h0000_5000, 32'h1, 1, 0));

        // random phases across several limits, one with no idle gaps
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_limit(32'hFFFF_FFFF);
                1: set_limit(32'h0000_9000);
                2: set_limit($urandom_range(32'h0008_0000, 32'h1000));
                3: set_limit(32'hC000_0000);
                default: set_limit($urandom_range(32'hFFFF_FFFF, 32'h1000));
            endcase
            quiet = (ph == 3);
            if (ph == 4) send_word(mk(FUNC_CLEAR, 32'h0, 32'h0, 0, 0));
            for (int n = 0; n < 150; n++) send_word(rand_word());
            drain();   // sender pauses until all results are in
        end
        quiet = 0;

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
